// ===== design/gopd_pkg.sv =====
// Package for the glyph outline point decoder: types, codes and constants.
// Used by the interfaces, the controller, the datapath and the top level.
package gopd_pkg;

    localparam int DATA_W        = 8;
    localparam int COORD_W       = 16;
    localparam int IDX_OUT_W     = 6;
    localparam int STATUS_W      = 2;
    localparam int FLAG_W        = 6;
    localparam int PT_CAP_DEF    = 64;

    // flag bits
    localparam int F_ON     = 0;
    localparam int F_XSHORT = 1;
    localparam int F_YSHORT = 2;
    localparam int F_REPEAT = 3;
    localparam int F_XSAME  = 4;
    localparam int F_YSAME  = 5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_NEG  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_NC_LO, S_BBOX, S_ENDPT, S_ILEN_HI, S_ILEN_LO, S_ISKIP,
        S_FLAG, S_FLAGREP, S_REPRUN, S_LOOKUP, S_EVAL, S_X, S_X_LO, S_Y, S_Y_LO
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_START, OP_HI, OP_COUNT, OP_BBOX, OP_ENDPT, OP_ILEN, OP_SKIP,
        OP_FLAG, OP_REPCNT, OP_REP, OP_COORD_BEGIN, OP_X_SHORT, OP_X_LO, OP_X_KEEP,
        OP_Y_BEGIN, OP_Y_SHORT, OP_Y_LO, OP_Y_KEEP
    } t_op;

    typedef enum logic [1:0] {
        EM_NONE, EM_STATUS, EM_POINT
    } t_emit;

    typedef struct packed {
        t_op                 op;
        t_emit               emit;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic neg;          // contour count negative
        logic compound;     // contour count all ones
        logic bbox_end;     // last bounding box byte
        logic cnt_odd;      // low byte of an end point
        logic endpt_last;   // last end point byte
        logic too_many;     // point count above capacity
        logic word_zero;    // 16-bit word being completed is zero
        logic skip_one;     // last instruction byte
        logic cc_zero;      // no contours
        logic total_zero;   // no points
        logic byte_repeat;  // repeat bit of incoming flag
        logic rep_go;       // repeat run still writing
        logic cur_done;     // cursor reached point total
        logic need_x;       // current point reads X bytes
        logic need_y;       // current point reads Y bytes
        logic x_short;
        logic y_short;
    } t_dp_stat;

endpackage

// ===== design/gopd_if.sv =====
// Valid/ready channel interfaces for the glyph outline point decoder.
// Depends on gopd_pkg for field widths.
interface gopd_in_if;
    logic                         valid;
    logic                         ready;
    logic [gopd_pkg::DATA_W-1:0]  data_byte;
    logic                         glyph_start;

    modport source (output valid, output data_byte, output glyph_start, input ready);
    modport sink   (input valid, input data_byte, input glyph_start, output ready);
endinterface

interface gopd_out_if;
    logic                                valid;
    logic                                ready;
    logic [gopd_pkg::IDX_OUT_W-1:0]      point_index;
    logic signed [gopd_pkg::COORD_W-1:0] x_coord;
    logic signed [gopd_pkg::COORD_W-1:0] y_coord;
    logic                                curve_bit;
    logic                                point_valid;
    logic                                last_result;
    logic [gopd_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output point_index, output x_coord, output y_coord,
                    output curve_bit, output point_valid, output last_result,
                    output status, input ready);
    modport sink   (input valid, input point_index, input x_coord, input y_coord,
                    input curve_bit, input point_valid, input last_result,
                    input status, output ready);
endinterface

// ===== design/gopd_ctrl.sv =====
// Parse controller: state machine that sequences the glyph record fields.
// Depends on gopd_pkg; drives gopd_dp through t_cmd, reads t_dp_stat.
module gopd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_glyph_start,
    input  logic              i_out_free,
    input  gopd_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output gopd_pkg::t_cmd    o_cmd
);
    import gopd_pkg::*;

    t_state r_state, n_state;
    logic   r_yph, n_yph;
    logic   w_acc;

    // byte-taking states wait for a free output slot
    always_comb begin
        unique case (r_state)
            S_REPRUN, S_LOOKUP, S_EVAL: o_in_ready = 1'b0;
            default:                    o_in_ready = i_out_free;
        endcase
    end
    assign w_acc = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        n_yph   = r_yph;
        if (w_acc && i_glyph_start) begin
            n_state = S_NC_LO;
        end else begin
            unique case (r_state)
                S_IDLE: ;
                S_NC_LO: if (w_acc) n_state = i_stat.neg ? S_IDLE : S_BBOX;
                S_BBOX: if (w_acc && i_stat.bbox_end) begin
                    n_state = i_stat.cc_zero ? S_ILEN_HI : S_ENDPT;
                end
                S_ENDPT: if (w_acc && i_stat.cnt_odd && i_stat.endpt_last) begin
                    n_state = i_stat.too_many ? S_IDLE : S_ILEN_HI;
                end
                S_ILEN_HI: if (w_acc) n_state = S_ILEN_LO;
                S_ILEN_LO: if (w_acc) begin
                    if (!i_stat.word_zero) n_state = S_ISKIP;
                    else                   n_state = i_stat.total_zero ? S_IDLE : S_FLAG;
                end
                S_ISKIP: if (w_acc && i_stat.skip_one) begin
                    n_state = i_stat.total_zero ? S_IDLE : S_FLAG;
                end
                S_FLAG: if (w_acc) n_state = i_stat.byte_repeat ? S_FLAGREP : S_REPRUN;
                S_FLAGREP: if (w_acc) n_state = S_REPRUN;
                S_REPRUN: begin
                    if (!i_stat.rep_go) begin
                        if (i_stat.cur_done) begin
                            n_state = S_LOOKUP;
                            n_yph   = 1'b0;
                        end else begin
                            n_state = S_FLAG;
                        end
                    end
                end
                S_LOOKUP: n_state = S_EVAL;
                S_EVAL: begin
                    if (!r_yph) begin
                        if (i_stat.cur_done) begin
                            n_state = S_LOOKUP;
                            n_yph   = 1'b1;
                        end else if (i_stat.need_x) begin
                            n_state = S_X;
                        end else begin
                            n_state = S_LOOKUP;
                        end
                    end else begin
                        if (i_stat.cur_done)    n_state = S_IDLE;
                        else if (i_stat.need_y) n_state = S_Y;
                        else if (i_out_free)    n_state = S_LOOKUP;
                    end
                end
                S_X: if (w_acc) n_state = i_stat.x_short ? S_LOOKUP : S_X_LO;
                S_X_LO: if (w_acc) n_state = S_LOOKUP;
                S_Y: if (w_acc) n_state = i_stat.y_short ? S_LOOKUP : S_Y_LO;
                S_Y_LO: if (w_acc) n_state = S_LOOKUP;
                default: n_state = S_IDLE;
            endcase
        end
    end

    // commands
    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.emit   = EM_NONE;
        o_cmd.status = ST_OK;
        if (w_acc && i_glyph_start) begin
            o_cmd.op = OP_START;
        end else begin
            unique case (r_state)
                S_IDLE: ;
                S_NC_LO: if (w_acc) begin
                    o_cmd.op = OP_COUNT;
                    if (i_stat.neg) begin
                        o_cmd.emit   = EM_STATUS;
                        o_cmd.status = i_stat.compound ? ST_COMPOUND : ST_BAD_NEG;
                    end
                end
                S_BBOX: if (w_acc) o_cmd.op = OP_BBOX;
                S_ENDPT: if (w_acc) begin
                    o_cmd.op = OP_ENDPT;
                    if (i_stat.cnt_odd && i_stat.endpt_last && i_stat.too_many) begin
                        o_cmd.emit   = EM_STATUS;
                        o_cmd.status = ST_TOO_MANY;
                    end
                end
                S_ILEN_HI: if (w_acc) o_cmd.op = OP_HI;
                S_ILEN_LO: if (w_acc) begin
                    o_cmd.op = OP_ILEN;
                    if (i_stat.word_zero && i_stat.total_zero) o_cmd.emit = EM_STATUS;
                end
                S_ISKIP: if (w_acc) begin
                    o_cmd.op = OP_SKIP;
                    if (i_stat.skip_one && i_stat.total_zero) o_cmd.emit = EM_STATUS;
                end
                S_FLAG: if (w_acc) o_cmd.op = OP_FLAG;
                S_FLAGREP: if (w_acc) o_cmd.op = OP_REPCNT;
                S_REPRUN: begin
                    if (i_stat.rep_go)        o_cmd.op = OP_REP;
                    else if (i_stat.cur_done) o_cmd.op = OP_COORD_BEGIN;
                end
                S_LOOKUP: ;
                S_EVAL: begin
                    if (!r_yph) begin
                        if (i_stat.cur_done)     o_cmd.op = OP_Y_BEGIN;
                        else if (!i_stat.need_x) o_cmd.op = OP_X_KEEP;
                    end else if (!i_stat.cur_done && !i_stat.need_y && i_out_free) begin
                        o_cmd.op   = OP_Y_KEEP;
                        o_cmd.emit = EM_POINT;
                    end
                end
                S_X: if (w_acc) o_cmd.op = i_stat.x_short ? OP_X_SHORT : OP_HI;
                S_X_LO: if (w_acc) o_cmd.op = OP_X_LO;
                S_Y: if (w_acc) begin
                    if (i_stat.y_short) begin
                        o_cmd.op   = OP_Y_SHORT;
                        o_cmd.emit = EM_POINT;
                    end else begin
                        o_cmd.op = OP_HI;
                    end
                end
                S_Y_LO: if (w_acc) begin
                    o_cmd.op   = OP_Y_LO;
                    o_cmd.emit = EM_POINT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_yph   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_yph   <= n_yph;
        end
    end

endmodule

// ===== design/gopd_dp.sv =====
// Datapath: field registers, flag and X stores, running sums, output register.
// Depends on gopd_pkg; executes t_cmd from gopd_ctrl and returns t_dp_stat.
module gopd_dp #(
    parameter int PT_CAP = gopd_pkg::PT_CAP_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [gopd_pkg::DATA_W-1:0]          i_data_byte,
    input  gopd_pkg::t_cmd                       i_cmd,
    input  logic                                 i_out_ready,
    output gopd_pkg::t_dp_stat                   o_stat,
    output logic                                 o_out_free,
    output logic                                 o_out_valid,
    output logic [gopd_pkg::IDX_OUT_W-1:0]       o_point_index,
    output logic signed [gopd_pkg::COORD_W-1:0]  o_x_coord,
    output logic signed [gopd_pkg::COORD_W-1:0]  o_y_coord,
    output logic                                 o_curve_bit,
    output logic                                 o_point_valid,
    output logic                                 o_last_result,
    output logic [gopd_pkg::STATUS_W-1:0]        o_status
);
    import gopd_pkg::*;

    localparam int IW = $clog2(PT_CAP);
    localparam int CW = IW + 1;

    logic [DATA_W-1:0]  r_hi, n_hi;
    logic [15:0]        r_cnt, n_cnt;
    logic [15:0]        r_cc, n_cc;
    logic [CW-1:0]      r_total, n_total;
    logic [15:0]        r_skip, n_skip;
    logic [CW-1:0]      r_cursor, n_cursor;
    logic [FLAG_W-1:0]  r_pend, n_pend;
    logic [DATA_W-1:0]  r_rep, n_rep;
    logic [COORD_W-1:0] r_rx, n_rx;
    logic [COORD_W-1:0] r_ry, n_ry;

    logic [FLAG_W-1:0]  flag_mem [PT_CAP];
    logic [COORD_W-1:0] x_mem    [PT_CAP];
    logic [FLAG_W-1:0]  r_rd_flag;
    logic [COORD_W-1:0] r_rd_x;

    logic               w_fwe, w_xwe;
    logic [FLAG_W-1:0]  w_fwd;
    logic [15:0]        w_word;
    logic [COORD_W-1:0] w_b16;
    logic [16:0]        w_cnt_p1;
    logic               w_cur_lt;
    logic [IW-1:0]      w_idx;
    logic               w_last_pt;

    logic               r_ov;
    logic [IDX_OUT_W-1:0] r_o_idx;
    logic [COORD_W-1:0] r_o_x, r_o_y;
    logic               r_o_on, r_o_pv, r_o_last;
    logic [STATUS_W-1:0] r_o_st;

    assign w_word    = {r_hi, i_data_byte};
    assign w_b16     = COORD_W'(i_data_byte);
    assign w_cur_lt  = r_cursor < r_total;
    assign w_idx     = r_cursor[IW-1:0];
    assign w_cnt_p1  = {1'b0, r_cnt} + 17'd1;
    assign w_last_pt = ({1'b0, r_cursor} + (CW+1)'(1)) >= {1'b0, r_total};

    assign o_stat.neg         = r_hi[DATA_W-1];
    assign o_stat.compound    = (w_word == 16'hFFFF);
    assign o_stat.bbox_end    = (r_cnt == 16'd7);
    assign o_stat.cnt_odd     = r_cnt[0];
    assign o_stat.endpt_last  = w_cnt_p1 >= {r_cc, 1'b0};
    assign o_stat.too_many    = ({1'b0, w_word} + 17'd1) > 17'(PT_CAP);
    assign o_stat.word_zero   = (w_word == 16'd0);
    assign o_stat.skip_one    = (r_skip == 16'd1);
    assign o_stat.cc_zero     = (r_cc == 16'd0);
    assign o_stat.total_zero  = (r_total == '0);
    assign o_stat.byte_repeat = i_data_byte[F_REPEAT];
    assign o_stat.rep_go      = (r_rep != '0) && w_cur_lt;
    assign o_stat.cur_done    = !w_cur_lt;
    assign o_stat.x_short     = r_rd_flag[F_XSHORT];
    assign o_stat.y_short     = r_rd_flag[F_YSHORT];
    assign o_stat.need_x      = r_rd_flag[F_XSHORT] || !r_rd_flag[F_XSAME];
    assign o_stat.need_y      = r_rd_flag[F_YSHORT] || !r_rd_flag[F_YSAME];

    always_comb begin
        n_hi = r_hi;   n_cnt = r_cnt;       n_cc = r_cc;    n_total = r_total;
        n_skip = r_skip; n_cursor = r_cursor; n_pend = r_pend; n_rep = r_rep;
        n_rx = r_rx;   n_ry = r_ry;
        w_fwe = 1'b0;  w_fwd = i_data_byte[FLAG_W-1:0];  w_xwe = 1'b0;
        case (i_cmd.op)
            OP_START: begin
                n_hi = i_data_byte; n_cnt = '0; n_total = '0; n_cursor = '0;
                n_skip = '0; n_rep = '0; n_rx = '0; n_ry = '0;
            end
            OP_HI:    n_hi = i_data_byte;
            OP_COUNT: begin
                n_cc  = w_word;
                n_cnt = '0;
            end
            OP_BBOX:  begin
                n_cnt = (r_cnt == 16'd7) ? 16'd0 : w_cnt_p1[15:0];
                if (r_cnt == 16'd7) n_total = '0;
            end
            OP_ENDPT: begin
                if (!r_cnt[0]) begin
                    n_hi = i_data_byte;
                end else if (o_stat.endpt_last && !o_stat.too_many) begin
                    n_total = CW'({1'b0, w_word} + 17'd1);
                end
                n_cnt = w_cnt_p1[15:0];
            end
            OP_ILEN:  n_skip = w_word;
            OP_SKIP:  n_skip = r_skip - 16'd1;
            OP_FLAG:  begin
                if (w_cur_lt) begin
                    w_fwe    = 1'b1;
                    n_cursor = r_cursor + CW'(1);
                end
                n_pend = i_data_byte[FLAG_W-1:0];
                n_rep  = '0;
            end
            OP_REPCNT: n_rep = i_data_byte;
            OP_REP:   begin
                w_fwe    = 1'b1;
                w_fwd    = r_pend;
                n_cursor = r_cursor + CW'(1);
                n_rep    = r_rep - DATA_W'(1);
            end
            OP_COORD_BEGIN: begin
                n_cursor = '0;
                n_rx     = '0;
            end
            OP_X_SHORT: begin
                n_rx     = r_rd_flag[F_XSAME] ? r_rx + w_b16 : r_rx - w_b16;
                w_xwe    = 1'b1;
                n_cursor = r_cursor + CW'(1);
            end
            OP_X_LO: begin
                n_rx     = r_rx + w_word;
                w_xwe    = 1'b1;
                n_cursor = r_cursor + CW'(1);
            end
            OP_X_KEEP: begin
                w_xwe    = 1'b1;
                n_cursor = r_cursor + CW'(1);
            end
            OP_Y_BEGIN: begin
                n_cursor = '0;
                n_ry     = '0;
            end
            OP_Y_SHORT: begin
                n_ry     = r_rd_flag[F_YSAME] ? r_ry + w_b16 : r_ry - w_b16;
                n_cursor = r_cursor + CW'(1);
            end
            OP_Y_LO: begin
                n_ry     = r_ry + w_word;
                n_cursor = r_cursor + CW'(1);
            end
            OP_Y_KEEP: n_cursor = r_cursor + CW'(1);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0; r_cnt <= '0; r_cc <= '0; r_total <= '0; r_skip <= '0;
            r_cursor <= '0; r_pend <= '0; r_rep <= '0; r_rx <= '0; r_ry <= '0;
        end else begin
            r_hi <= n_hi; r_cnt <= n_cnt; r_cc <= n_cc; r_total <= n_total;
            r_skip <= n_skip; r_cursor <= n_cursor; r_pend <= n_pend;
            r_rep <= n_rep; r_rx <= n_rx; r_ry <= n_ry;
        end
    end

    // stores: one write port, registered read at the cursor
    always_ff @(posedge i_clk) begin
        if (w_fwe) flag_mem[w_idx] <= w_fwd;
        if (w_xwe) x_mem[w_idx]    <= n_rx;
        r_rd_flag <= flag_mem[w_idx];
        r_rd_x    <= x_mem[w_idx];
    end

    // output register
    assign o_out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit == EM_POINT) begin
            r_o_idx  <= IDX_OUT_W'(w_idx);
            r_o_x    <= r_rd_x;
            r_o_y    <= n_ry;
            r_o_on   <= r_rd_flag[F_ON];
            r_o_pv   <= 1'b1;
            r_o_last <= w_last_pt;
            r_o_st   <= ST_OK;
        end else if (i_cmd.emit == EM_STATUS) begin
            r_o_idx  <= '0;
            r_o_x    <= '0;
            r_o_y    <= '0;
            r_o_on   <= 1'b0;
            r_o_pv   <= 1'b0;
            r_o_last <= 1'b1;
            r_o_st   <= i_cmd.status;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_point_index = r_o_idx;
    assign o_x_coord     = r_o_x;
    assign o_y_coord     = r_o_y;
    assign o_curve_bit   = r_o_on;
    assign o_point_valid = r_o_pv;
    assign o_last_result = r_o_last;
    assign o_status      = r_o_st;

`ifndef SYNTH
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_total) else $error("cursor past point total");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(PT_CAP)) else $error("point total above capacity");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != EM_NONE) |-> o_out_free) else $error("result overwritten");
    a_point_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_pv) |-> (r_o_st == ST_OK)) else $error("point with error status");
`endif

endmodule

// ===== design/glyph_outline_point_decoder.sv =====
// Top level of the glyph outline point decoder: joins controller and datapath.
// Depends on gopd_pkg, gopd_if, gopd_ctrl and gopd_dp.
//
//  channel  | dir | modport | payload
//  i_in     | in  | sink    | data_byte, glyph_start
//  o_out    | out | source  | point_index, x_coord, y_coord, curve_bit,
//           |     |         | point_valid, last_result, status
//
// A flag byte is stored and then passes through a run state; its repeat count byte
// adds a write of the flag to the flag store for each repeat.
// Each point of either coordinate pass first reads the stores at the cursor, then
// is evaluated; the switch from X to Y and the end of Y also pass through both steps.
// Reset (i_rst_n low, synchronous) returns to waiting for a glyph start.
// A byte is taken only while the output register is free or being drained,
// so a stalled sink holds the input; the output register holds one result.
module glyph_outline_point_decoder #(
    parameter int PT_CAP = gopd_pkg::PT_CAP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gopd_in_if.sink    i_in,
    gopd_out_if.source o_out
);
    import gopd_pkg::*;

    t_cmd     w_cmd;
    t_dp_stat w_stat;
    logic     w_out_free;
    logic     w_in_ready;

    // sequencing of record fields
    gopd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_glyph_start (i_in.glyph_start),
        .i_out_free    (w_out_free),
        .i_stat        (w_stat),
        .o_in_ready    (w_in_ready),
        .o_cmd         (w_cmd)
    );

    // field registers, stores and result register
    gopd_dp #(
        .PT_CAP (PT_CAP)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in.data_byte),
        .i_cmd         (w_cmd),
        .i_out_ready   (o_out.ready),
        .o_stat        (w_stat),
        .o_out_free    (w_out_free),
        .o_out_valid   (o_out.valid),
        .o_point_index (o_out.point_index),
        .o_x_coord     (o_out.x_coord),
        .o_y_coord     (o_out.y_coord),
        .o_curve_bit   (o_out.curve_bit),
        .o_point_valid (o_out.point_valid),
        .o_last_result (o_out.last_result),
        .o_status      (o_out.status)
    );

    assign i_in.ready = w_in_ready;

endmodule

// ===== tb/gopd_point_checker.sv =====
// Checker for the glyph outline point decoder: predicts points from the byte stream.
// Depends on gopd_pkg and the gopd_in_if / gopd_out_if channel interfaces.
module gopd_point_checker #(
    parameter int PT_CAP = gopd_pkg::PT_CAP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gopd_in_if.sink    i_in,
    gopd_out_if.sink   i_out,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gopd_pkg::*;

    typedef enum int {
        P_IDLE, P_NC_HI, P_NC_LO, P_BBOX, P_ENDPT, P_ILEN_HI, P_ILEN_LO, P_ISKIP,
        P_FLAG, P_FLAGREP, P_X, P_X_LO, P_Y, P_Y_LO
    } t_phase;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic                 on;
        logic                 pv;
        logic                 last;
        logic [STATUS_W-1:0]  st;
    } t_point;

    t_point        expected_points[$];
    t_phase        phase;
    int unsigned   cnt, ncont, total, cursor;
    logic [7:0]    hi_byte;
    logic [5:0]    rep_flag;
    logic [15:0]   skip, run_x, run_y;
    logic [5:0]    flags[PT_CAP];
    logic [15:0]   xs[PT_CAP];
    int            fails;
    int            pend;

    assign o_fail_count = fails;
    assign o_pending    = pend;

    task automatic report(input string what);
        $display("checker: %s at %0t", what, $realtime);
        fails++;
    endtask

    function automatic logic [5:0] flag_of(int unsigned i);
        return (i < PT_CAP) ? flags[i] : 6'd0;
    endfunction

    task automatic push_status(input logic [1:0] st);
        t_point p;
        p = '0; p.last = 1'b1; p.st = st;
        expected_points.insert(expected_points.size(), p);
        phase = P_IDLE;
    endtask

    task automatic push_point();
        t_point p;
        logic [5:0] f;
        f = flag_of(cursor);
        p.idx = cursor[5:0];
        p.x = (cursor < PT_CAP) ? xs[cursor] : 16'd0;
        p.y = run_y;
        p.on = f[F_ON];
        p.pv = 1'b1;
        p.last = (cursor + 1 >= total);
        p.st = ST_OK;
        expected_points.insert(expected_points.size(), p);
        cursor++;
        if (cursor >= total) phase = P_IDLE;
    endtask

    // resolve points whose coordinate needs no byte
    task automatic settle();
        logic [5:0] f;
        forever begin
            if (phase == P_X) begin
                if (cursor >= total) begin
                    phase = P_Y; cursor = 0; run_y = '0;
                    continue;
                end
                f = flag_of(cursor);
                if (f[F_XSHORT] || !f[F_XSAME]) return;
                if (cursor < PT_CAP) xs[cursor] = run_x;
                cursor++;
            end else if (phase == P_Y) begin
                if (cursor >= total) begin
                    phase = P_IDLE;
                    return;
                end
                f = flag_of(cursor);
                if (f[F_YSHORT] || !f[F_YSAME]) return;
                push_point();
            end else begin
                return;
            end
        end
    endtask

    task automatic begin_flags();
        if (total == 0) push_status(ST_OK);
        else begin
            phase = P_FLAG; cursor = 0;
        end
    endtask

    task automatic begin_coords();
        phase = P_X; cursor = 0; run_x = '0;
        settle();
    endtask

    task automatic finish_x();
        if (cursor < PT_CAP) xs[cursor] = run_x;
        cursor++;
        phase = P_X;
        settle();
    endtask

    task automatic finish_y();
        phase = P_Y;
        push_point();
        settle();
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic gs);
        logic [5:0]  f;
        logic [15:0] w;
        if (gs) begin
            phase = P_NC_HI; cnt = 0; total = 0; cursor = 0; skip = '0;
            rep_flag = '0; run_x = '0; run_y = '0;
        end
        case (phase)
            P_NC_HI: begin
                hi_byte = b; phase = P_NC_LO;
            end
            P_NC_LO: begin
                w = {hi_byte, b};
                ncont = 32'(w);
                if (w[15]) push_status((w == 16'hFFFF) ? ST_COMPOUND : ST_BAD_NEG);
                else begin
                    phase = P_BBOX; cnt = 0;
                end
            end
            P_BBOX: begin
                cnt++;
                if (cnt >= 8) begin
                    cnt = 0;
                    if (ncont == 0) begin
                        total = 0; phase = P_ILEN_HI;
                    end else phase = P_ENDPT;
                end
            end
            P_ENDPT: begin
                if (cnt % 2 == 0) hi_byte = b;
                else if (cnt + 1 >= 2 * ncont) begin
                    if ({16'd0, hi_byte, b} + 1 > PT_CAP) begin
                        push_status(ST_TOO_MANY);
                        return;
                    end
                    total = {hi_byte, b} + 1;
                    phase = P_ILEN_HI;
                end
                cnt++;
            end
            P_ILEN_HI: begin
                hi_byte = b; phase = P_ILEN_LO;
            end
            P_ILEN_LO: begin
                skip = {hi_byte, b};
                if (skip == 0) begin_flags();
                else phase = P_ISKIP;
            end
            P_ISKIP: begin
                skip--;
                if (skip == 0) begin_flags();
            end
            P_FLAG: begin
                f = b[5:0];
                if (cursor < total && cursor < PT_CAP) begin
                    flags[cursor] = f; cursor++;
                end
                if (f[F_REPEAT]) begin
                    rep_flag = f; phase = P_FLAGREP;
                end else if (cursor >= total) begin_coords();
            end
            P_FLAGREP: begin
                for (int r = 0; r < b && cursor < total && cursor < PT_CAP; r++) begin
                    flags[cursor] = rep_flag; cursor++;
                end
                if (cursor >= total) begin_coords();
                else phase = P_FLAG;
            end
            P_X: begin
                f = flag_of(cursor);
                if (f[F_XSHORT]) begin
                    run_x = f[F_XSAME] ? run_x + b : run_x - b;
                    finish_x();
                end else begin
                    hi_byte = b; phase = P_X_LO;
                end
            end
            P_X_LO: begin
                run_x = run_x + {hi_byte, b};
                finish_x();
            end
            P_Y: begin
                f = flag_of(cursor);
                if (f[F_YSHORT]) begin
                    run_y = f[F_YSAME] ? run_y + b : run_y - b;
                    finish_y();
                end else begin
                    hi_byte = b; phase = P_Y_LO;
                end
            end
            P_Y_LO: begin
                run_y = run_y + {hi_byte, b};
                finish_y();
            end
            default: phase = P_IDLE;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_point exp_p;
        if (!i_rst_n) begin
            phase = P_IDLE;
            fails = 0;
            expected_points.delete();
        end else begin
            // output side first: a result can't come from a byte taken this edge
            if (i_out.valid && i_out.ready) begin
                if (expected_points.size() == 0) report("unexpected result transaction");
                else begin
                    exp_p = expected_points.pop_front();
                    if (i_out.point_index !== exp_p.idx)  report("point_index mismatch");
                    if (i_out.x_coord !== exp_p.x)        report("x_coord mismatch");
                    if (i_out.y_coord !== exp_p.y)        report("y_coord mismatch");
                    if (i_out.curve_bit !== exp_p.on)     report("curve_bit mismatch");
                    if (i_out.point_valid !== exp_p.pv)   report("point_valid mismatch");
                    if (i_out.last_result !== exp_p.last) report("last_result mismatch");
                    if (i_out.status !== exp_p.st)        report("status mismatch");
                end
            end
            if (i_in.valid && i_in.ready) decode_byte(i_in.data_byte, i_in.glyph_start);
        end
        pend = expected_points.size();
    end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top for glyph_outline_point_decoder: builds glyph byte streams and drives them.
// Depends on gopd_pkg, gopd_if, the decoder RTL and gopd_point_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gopd_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, pending, cycles;
    int   send_idle_pct, recv_idle_pct;
    int   sent_bytes;
    logic [7:0] glyph_bytes[$];

    gopd_in_if  in_ch();
    gopd_out_if out_ch();

    glyph_outline_point_decoder uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    gopd_point_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .i_out(out_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #6 i_clk = ~i_clk;

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // sink side: random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else          out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one byte as one transaction, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic gs);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.glyph_start <= gs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_glyph();
        foreach (glyph_bytes[i]) send_byte(glyph_bytes[i], i == 0);
        glyph_bytes.delete();
    endtask

    task automatic put8(input logic [7:0] b);
        glyph_bytes.insert(glyph_bytes.size(), b);
    endtask

    task automatic put16(input logic [15:0] w);
        put8(w[15:8]);
        put8(w[7:0]);
    endtask

    // well-formed simple glyph with random content; ends with last end point npts-1
    task automatic build_glyph(input int npts, input int ncont, input int ilen,
                               input bit use_repeat);
        logic [7:0] fl[$];
        int i, rep;
        logic [7:0] f;
        put16(ncont[15:0]);
        repeat (8) put8(8'($urandom_range(255)));
        for (i = 0; i < ncont; i++)
            put16((i == ncont - 1) ? 16'(npts - 1) : 16'($urandom_range(65535)));
        put16(ilen[15:0]);
        repeat (ilen) put8(8'($urandom_range(255)));
        if (npts == 0 || ncont == 0) return;
        i = 0;
        while (i < npts) begin
            f = 8'($urandom_range(255));
            if (use_repeat && $urandom_range(3) == 0) begin
                f[F_REPEAT] = 1'b1;
                rep = $urandom_range(0, 6);
                put8(f);
                put8(rep[7:0]);
                for (int k = 0; k <= rep && i < npts; k++) begin
                    fl.insert(fl.size(), f); i++;
                end
            end else begin
                f[F_REPEAT] = 1'b0;
                put8(f);
                fl.insert(fl.size(), f); i++;
            end
        end
        foreach (fl[k]) begin
            if (fl[k][F_XSHORT]) put8(8'($urandom_range(255)));
            else if (!fl[k][F_XSAME]) put16(16'($urandom_range(65535)));
        end
        foreach (fl[k]) begin
            if (fl[k][F_YSHORT]) put8(8'($urandom_range(255)));
            else if (!fl[k][F_YSAME]) put16(16'($urandom_range(65535)));
        end
    endtask

    task automatic random_phase(input int n_bytes);
        int start, sel, k;
        start = sent_bytes;
        while (sent_bytes - start < n_bytes) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
                build_glyph(($urandom_range(3) == 0) ? $urandom_range(1, 64)
                            : $urandom_range(1, 10),
                            $urandom_range(1, 3), $urandom_range(0, 3), 1'b1);
                send_glyph();
            end else if (sel < 85) begin
                // truncated glyph: the next start drops it
                build_glyph($urandom_range(1, 12), 1, $urandom_range(0, 2), 1'b1);
                k = $urandom_range(1, glyph_bytes.size());
                while (glyph_bytes.size() > k) void'(glyph_bytes.pop_back());
                send_glyph();
            end else if (sel < 92) begin
                put16(16'h8000 | 16'($urandom_range(32767)));
                send_glyph();
            end else begin
                // noise, sometimes hitting idle without a start
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end
    endtask

    // let the outstanding results drain, then a little more for the last byte
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= '0;
        in_ch.glyph_start <= 1'b0;
        sent_bytes = 0;
        send_idle_pct = 9;
        recv_idle_pct = 59;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray byte while idle, compound, other negative, zero contours
        send_byte(8'hFF, 1'b0);
        put16(16'hFFFF); send_glyph();
        put16(16'h8000); send_glyph();
        build_glyph(0, 0, 0, 0); send_glyph();
        build_glyph(0, 0, 3, 0); send_glyph();
        // too many points
        put16(16'd1); repeat (8) put8(8'h00); put16(16'd64); send_glyph();
        // extremes: long deltas 0x7FFF/0x8000, keep-previous, short both signs
        put16(16'd1); repeat (8) put8(8'hA5); put16(16'd4); put16(16'd0);
        put8(8'h01);             // long X, long Y, on
        put8(8'h36);             // short X +, short Y +
        put8(8'h06);             // short X -, short Y -
        put8(8'hF0 | 8'h01);     // keep X, keep Y, bits 6/7 set
        put8(8'h38);             // repeat: keep both
        put8(8'd200);            // repeat past the last point
        put16(16'h7FFF); put8(8'hFF); put8(8'hFF);
        put16(16'h8000);
        put16(16'hFFFF);
        // points all done by now: the rest arrive while idle
        put8(8'h00); put8(8'hFF);
        put16(16'h8000);
        send_glyph();
        // full 64-point glyph, all keep: one byte yields every result
        put16(16'd1); repeat (8) put8(8'h00); put16(16'd63); put16(16'd0);
        put8(8'h39); put8(8'd63);
        send_glyph();
        drain();

        random_phase(120);
        drain();
        send_idle_pct = 59;
        recv_idle_pct = 9;
        random_phase(120);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(120);
        drain();

        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/gopd_pkg.sv
design/gopd_if.sv
design/gopd_ctrl.sv
design/gopd_dp.sv
design/glyph_outline_point_decoder.sv
tb/gopd_point_checker.sv
tb/tb_top.sv
